### src/bdq_pkg.sv
// shared constants and types of the birth-death queue steady-state solver
package bdq_pkg;

    localparam int MAX_STATES = 64;
    localparam int PROB_BITS  = 32;
    localparam int WORD_W     = 32;
    // big-number length in 32-bit words, arithmetic wraps at this length
    localparam int BN_WORDS   = (MAX_STATES * 48 + 128) / 32 + 2;
    localparam int K_W        = $clog2(MAX_STATES);
    localparam int J_W        = $clog2(BN_WORDS);
    localparam int Q_PASSES   = PROB_BITS + 2;
    localparam int BIT_W      = $clog2(Q_PASSES);

    localparam logic [2:0] CFG_SERVER_COUNT   = 3'd0;
    localparam logic [2:0] CFG_QUEUE_CAPACITY = 3'd1;
    localparam logic [2:0] CFG_ARRIVAL_RATE   = 3'd2;
    localparam logic [2:0] CFG_SERVICE_RATE   = 3'd3;
    localparam logic [2:0] CFG_ABANDON_RATE   = 3'd4;
    localparam logic [2:0] CFG_SOURCE_COUNT   = 3'd5;

    typedef struct packed {
        logic [5:0]  server_count;
        logic [5:0]  queue_capacity;
        logic [31:0] arrival_rate;
        logic [31:0] service_rate;
        logic [31:0] abandon_rate;
        logic [15:0] source_count;
    } t_cfg;

    typedef struct packed {
        logic                 push;
        logic [5:0]           state_index;
        logic [PROB_BITS-1:0] probability;
        logic                 config_error;
        logic                 last_result;
    } t_result;

endpackage

### src/birth_death_queue_steady_state_top.sv
// top level of the birth-death queue steady-state solver
//
// usage
// - config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) writes
//   server count, queue capacity, arrival, service and abandon rates and the
//   source count; always ready, write only while the solver is idle
// - request channel (i_valid/o_ready, i_solve_request): a request with
//   i_solve_request high starts one solve; a low request is taken and dropped
// - result channel (o_valid/i_ready) gives one probability per state
//   0 .. S-1 in order, S = servers + capacity + 1, last_result on the final
//   one; S above 64 gives a single config_error result instead
// - product-form weights are built word by word in a weight memory with one
//   32x32 multiplier pair, then each weight is divided by the total with a
//   restoring divider over a scratch memory, one bit per memory sweep
// - a config error result passes through the solver's error state and the
//   output register before it shows on o_valid
// - o_ready is high only while the solver is idle, with no solve or error pending
// - a stalled receiver holds the output register; the solver waits for it
//   before presenting the next probability
// - reset restores the documented register defaults and drops any run
module birth_death_queue_steady_state_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_solve_request,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_state_index,
    output logic [31:0] o_probability,
    output logic        o_config_error,
    output logic        o_last_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import bdq_pkg::*;

    t_cfg    r_cfg;
    t_result res;
    logic    idle;
    logic    start;
    logic    out_free;

    logic        r_out_valid;
    logic [5:0]  r_state_index;
    logic [31:0] r_probability;
    logic        r_config_error;
    logic        r_last_result;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.server_count   <= 6'd1;
            r_cfg.queue_capacity <= 6'd0;
            r_cfg.arrival_rate   <= 32'd65536;
            r_cfg.service_rate   <= 32'd65536;
            r_cfg.abandon_rate   <= 32'd0;
            r_cfg.source_count   <= 16'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SERVER_COUNT:   r_cfg.server_count   <= i_cfg_data[5:0];
                CFG_QUEUE_CAPACITY: r_cfg.queue_capacity <= i_cfg_data[5:0];
                CFG_ARRIVAL_RATE:   r_cfg.arrival_rate   <= i_cfg_data;
                CFG_SERVICE_RATE:   r_cfg.service_rate   <= i_cfg_data;
                CFG_ABANDON_RATE:   r_cfg.abandon_rate   <= i_cfg_data;
                CFG_SOURCE_COUNT:   r_cfg.source_count   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // a request only starts work when it asks for a solve
    assign o_ready  = idle;
    assign start    = i_valid && idle && i_solve_request;
    assign out_free = !r_out_valid || i_ready;

    bdq_solver u_solver (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .i_cfg      (r_cfg),
        .o_idle     (idle),
        .o_result   (res)
    );

    // output register between solver and receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.push) begin
            r_state_index  <= res.state_index;
            r_probability  <= res.probability;
            r_config_error <= res.config_error;
            r_last_result  <= res.last_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_state_index  = r_state_index;
    assign o_probability  = r_probability;
    assign o_config_error = r_config_error;
    assign o_last_result  = r_last_result;

endmodule

### src/bdq_factor.sv
// rate factor pipeline: arrival numerator or denominator-scaled departure rate
module bdq_factor (
    input  logic           i_clk,
    input  bdq_pkg::t_cfg  i_cfg,
    input  logic [5:0]     i_s,
    input  logic           i_use_arrival,
    output logic [63:0]    o_factor
);
    import bdq_pkg::*;

    logic [5:0]  busy;
    logic [5:0]  waiting;
    logic [15:0] n_minus_s;
    logic [15:0] denom;

    logic [37:0] r_busy_prod;
    logic [37:0] r_wait_prod;
    logic [47:0] r_arr_prod;
    logic        r_arr_zero;
    logic        r_arr_plain;
    logic [38:0] r_dep;
    logic [47:0] r_arr;
    logic [63:0] r_factor;

    always_comb begin
        busy      = (i_s < i_cfg.server_count) ? i_s : i_cfg.server_count;
        waiting   = (i_s > i_cfg.server_count) ? (i_s - i_cfg.server_count) : 6'd0;
        n_minus_s = i_cfg.source_count - {10'd0, i_s};
        denom     = (i_cfg.source_count == 16'd0) ? 16'd1 : i_cfg.source_count;
    end

    always_ff @(posedge i_clk) begin
        r_busy_prod <= 38'(busy) * 38'(i_cfg.service_rate);
        r_wait_prod <= 38'(waiting) * 38'(i_cfg.abandon_rate);
        r_arr_prod  <= 48'(i_cfg.arrival_rate) * 48'(n_minus_s);
        r_arr_plain <= (i_cfg.source_count == 16'd0);
        r_arr_zero  <= ({10'd0, i_s} >= i_cfg.source_count);

        r_dep <= 39'(r_busy_prod) + 39'(r_wait_prod);
        if (r_arr_plain) begin
            r_arr <= 48'(i_cfg.arrival_rate);
        end else if (r_arr_zero) begin
            r_arr <= 48'd0;
        end else begin
            r_arr <= r_arr_prod;
        end

        if (i_use_arrival) begin
            r_factor <= 64'(r_arr);
        end else begin
            r_factor <= 64'(denom) * 64'(r_dep);
        end
    end

    assign o_factor = r_factor;

endmodule

### src/bdq_solver.sv
// sequencer and big-number datapath over the weight and scratch memories
module bdq_solver (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_out_free,
    input  bdq_pkg::t_cfg     i_cfg,
    output logic              o_idle,
    output bdq_pkg::t_result  o_result
);
    import bdq_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ERR    = 4'd1;
    localparam logic [3:0] ST_INIT   = 4'd2;
    localparam logic [3:0] ST_FSEL   = 4'd3;
    localparam logic [3:0] ST_FWAIT  = 4'd4;
    localparam logic [3:0] ST_MUL    = 4'd5;
    localparam logic [3:0] ST_ADD    = 4'd6;
    localparam logic [3:0] ST_QSTART = 4'd7;
    localparam logic [3:0] ST_QPASS  = 4'd8;
    localparam logic [3:0] ST_QEND   = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    localparam logic [1:0] ROW_TOTAL = 2'd0;
    localparam logic [1:0] ROW_REM0  = 2'd1;
    localparam logic [1:0] ROW_REM1  = 2'd2;

    localparam logic [J_W-1:0]   J_LAST = J_W'(BN_WORDS - 1);
    localparam logic [BIT_W-1:0] Q_LAST = BIT_W'(Q_PASSES - 1);

    // weight store: one row of words per state
    logic [WORD_W-1:0] wmem [MAX_STATES * (2 ** J_W)];
    // scratch: running total and a pair of remainder rows
    logic [WORD_W-1:0] smem [4 * (2 ** J_W)];

    logic [3:0]         r_st;
    logic [K_W-1:0]     r_k;
    logic [K_W:0]       r_s;
    logic [J_W-1:0]     r_j;
    logic [1:0]         r_ph;
    logic [BIT_W-1:0]   r_bit;
    logic [1:0]         r_cnt;
    logic               r_cur;
    logic               r_nz;
    logic [33:0]        r_carry;
    logic [31:0]        r_prevx;
    logic [63:0]        r_p0;
    logic [63:0]        r_p1;
    logic               r_sh;
    logic               r_borrow;
    logic [31:0]        r_sword;
    logic [PROB_BITS+1:0] r_q;
    logic [PROB_BITS+1:0] n_q;

    logic [31:0] r_wrd;
    logic [31:0] r_trd;
    logic [31:0] r_rrd;

    logic [6:0]     nst;
    logic           cfg_err;
    logic [K_W-1:0] last;
    logic [63:0]    fac;
    logic [1:0]     cur_row;
    logic [1:0]     oth_row;
    logic           last_ph;
    logic           word_end;

    logic [65:0] mul_acc;
    logic [31:0] add_t;
    logic [33:0] add_sum;
    logic [31:0] q_x;
    logic [31:0] q_s;
    logic [32:0] q_d;
    logic        ge;

    logic                  w_we;
    logic [K_W+J_W-1:0]    w_addr;
    logic [31:0]           w_wdata;
    logic                  s_we;
    logic [J_W+1:0]        s_waddr;
    logic [31:0]           s_wdata;

    bdq_factor u_factor (
        .i_clk         (i_clk),
        .i_cfg         (i_cfg),
        .i_s           (r_s[K_W-1:0]),
        .i_use_arrival (r_s < {1'b0, r_k}),
        .o_factor      (fac)
    );

    always_comb begin
        nst      = 7'(i_cfg.server_count) + 7'(i_cfg.queue_capacity) + 7'd1;
        cfg_err  = nst > 7'(MAX_STATES);
        last     = K_W'(nst - 7'd1);
        cur_row  = r_cur ? ROW_REM1 : ROW_REM0;
        oth_row  = r_cur ? ROW_REM0 : ROW_REM1;
        last_ph  = (r_st == ST_QPASS) ? (r_ph == 2'd3) : (r_ph == 2'd2);
        word_end = last_ph && (r_j == J_LAST);

        mul_acc = 66'(r_p0) + 66'(r_p1) + 66'(r_carry);
        add_t   = (r_k == '0) ? 32'd0 : r_trd;
        add_sum = 34'(r_wrd) + 34'(add_t) + r_carry;
        q_x     = (r_bit == '0) ? r_wrd : r_rrd;
        q_s     = (r_bit == '0) ? q_x : {q_x[30:0], r_sh};
        q_d     = {1'b0, q_s} - {1'b0, r_trd} - 33'(r_borrow);
        ge      = !r_borrow;

        priority if (r_bit == '0) begin
            n_q = (PROB_BITS+2)'(ge);
        end else if (r_bit == Q_LAST) begin
            n_q = r_q + (PROB_BITS+2)'(ge);
        end else begin
            n_q = {r_q[PROB_BITS:0], ge};
        end

        w_addr  = {r_k, r_j};
        w_we    = ((r_st == ST_INIT) || (r_st == ST_MUL)) && (r_ph == 2'd2);
        if (r_st == ST_INIT) begin
            w_wdata = (r_j == '0) ? 32'd1 : 32'd0;
        end else begin
            w_wdata = mul_acc[31:0];
        end

        s_we    = 1'b0;
        s_waddr = {ROW_TOTAL, r_j};
        s_wdata = add_sum[31:0];
        if ((r_st == ST_ADD) && (r_ph == 2'd2)) begin
            s_we = 1'b1;
        end else if ((r_st == ST_QPASS) && (r_ph == 2'd2)) begin
            s_we    = 1'b1;
            s_waddr = {oth_row, r_j};
            s_wdata = q_d[31:0];
        end else if ((r_st == ST_QPASS) && (r_ph == 2'd3)) begin
            s_we    = 1'b1;
            s_waddr = {cur_row, r_j};
            s_wdata = r_sword;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            wmem[w_addr] <= w_wdata;
        end
        r_wrd <= wmem[{r_k, r_j}];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            smem[s_waddr] <= s_wdata;
        end
        r_trd <= smem[{ROW_TOTAL, r_j}];
        r_rrd <= smem[{cur_row, r_j}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_k   <= '0;
            r_s   <= '0;
            r_j   <= '0;
            r_ph  <= '0;
            r_bit <= '0;
            r_cnt <= '0;
            r_cur <= 1'b0;
            r_nz  <= 1'b0;
        end else begin
            // word stepping shared by every pass
            if ((r_st == ST_INIT) || (r_st == ST_MUL) || (r_st == ST_ADD) ||
                (r_st == ST_QPASS)) begin
                if (last_ph) begin
                    r_ph <= 2'd0;
                    if (!word_end) begin
                        r_j <= r_j + 1'b1;
                    end
                end else begin
                    r_ph <= r_ph + 1'b1;
                end
            end

            unique case (r_st)
                ST_IDLE: begin
                    if (i_start) begin
                        if (cfg_err) begin
                            r_st <= ST_ERR;
                        end else begin
                            r_k  <= '0;
                            r_j  <= '0;
                            r_ph <= '0;
                            r_st <= ST_INIT;
                        end
                    end
                end
                ST_ERR: begin
                    if (i_out_free) begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_INIT: begin
                    if (word_end) begin
                        r_s  <= '0;
                        r_st <= ST_FSEL;
                    end
                end
                ST_FSEL: begin
                    if (r_s > {1'b0, last}) begin
                        r_j     <= '0;
                        r_ph    <= '0;
                        r_carry <= '0;
                        r_nz    <= 1'b0;
                        r_st    <= ST_ADD;
                    end else if (r_s == {1'b0, r_k}) begin
                        r_s <= r_s + 1'b1;
                    end else begin
                        r_cnt <= '0;
                        r_st  <= ST_FWAIT;
                    end
                end
                ST_FWAIT: begin
                    // factor pipeline settles
                    if (r_cnt == 2'd3) begin
                        r_j     <= '0;
                        r_ph    <= '0;
                        r_carry <= '0;
                        r_prevx <= '0;
                        r_st    <= ST_MUL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_MUL: begin
                    if (r_ph == 2'd1) begin
                        r_p0    <= 64'(r_wrd) * 64'(fac[31:0]);
                        r_p1    <= 64'(r_prevx) * 64'(fac[63:32]);
                        r_prevx <= r_wrd;
                    end
                    if (r_ph == 2'd2) begin
                        r_carry <= mul_acc[65:32];
                    end
                    if (word_end) begin
                        r_s  <= r_s + 1'b1;
                        r_st <= ST_FSEL;
                    end
                end
                ST_ADD: begin
                    if (r_ph == 2'd2) begin
                        r_carry <= 34'(add_sum[33:32]);
                        r_nz    <= r_nz | (|add_sum[31:0]);
                    end
                    if (word_end) begin
                        if (r_k == last) begin
                            r_k  <= '0;
                            r_st <= ST_QSTART;
                        end else begin
                            r_k  <= r_k + 1'b1;
                            r_j  <= '0;
                            r_st <= ST_INIT;
                        end
                    end
                end
                ST_QSTART: begin
                    if (r_nz) begin
                        r_bit    <= '0;
                        r_cur    <= 1'b0;
                        r_j      <= '0;
                        r_ph     <= '0;
                        r_borrow <= 1'b0;
                        r_sh     <= 1'b0;
                        r_st     <= ST_QPASS;
                    end else begin
                        r_q  <= '0;
                        r_st <= ST_OUT;
                    end
                end
                ST_QPASS: begin
                    if (r_ph == 2'd2) begin
                        r_sword  <= q_s;
                        r_sh     <= q_x[31];
                        r_borrow <= q_d[32];
                    end
                    if (word_end) begin
                        r_st <= ST_QEND;
                    end
                end
                ST_QEND: begin
                    r_q <= n_q;
                    if (ge && (r_bit != Q_LAST)) begin
                        r_cur <= !r_cur;
                    end
                    if (r_bit == Q_LAST) begin
                        r_st <= ST_OUT;
                    end else begin
                        r_bit    <= r_bit + 1'b1;
                        r_j      <= '0;
                        r_ph     <= '0;
                        r_borrow <= 1'b0;
                        r_sh     <= 1'b0;
                        r_st     <= ST_QPASS;
                    end
                end
                ST_OUT: begin
                    if (i_out_free) begin
                        if (r_k == last) begin
                            r_st <= ST_IDLE;
                        end else begin
                            r_k  <= r_k + 1'b1;
                            r_st <= ST_QSTART;
                        end
                    end
                end
                default: begin
                    r_st <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_idle                = (r_st == ST_IDLE);
        o_result.push         = ((r_st == ST_ERR) || (r_st == ST_OUT)) && i_out_free;
        o_result.config_error = (r_st == ST_ERR);
        if (r_st == ST_ERR) begin
            o_result.state_index = 6'd0;
            o_result.probability = '0;
            o_result.last_result = 1'b1;
        end else begin
            o_result.state_index = 6'(r_k);
            o_result.probability = (|r_q[PROB_BITS+1:PROB_BITS]) ? '1 :
                                   r_q[PROB_BITS-1:0];
            o_result.last_result = (r_k == last);
        end
    end

endmodule

### test/tb_birth_death_queue_steady_state_top.sv
// testbench of the birth-death queue steady-state solver top level
module tb_birth_death_queue_steady_state_top;
    import bdq_pkg::*;

    // big numbers wrap at the same length as the solver's arithmetic, BN_WORDS words
    localparam int BIG_W = BN_WORDS * 32;

    typedef struct {
        logic [5:0]  state_index;
        logic [31:0] probability;
        logic        config_error;
        logic        last_result;
    } t_prob_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_solve_request;
    logic        o_valid;
    logic        i_ready;
    logic [5:0]  o_state_index;
    logic [31:0] o_probability;
    logic        o_config_error;
    logic        o_last_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    birth_death_queue_steady_state_top DUT (.*);

    // registers as the testbench believes them to be
    t_cfg cur_cfg;

    t_prob_result expected_probs[$];
    int  mismatches;
    int  solves_sent;
    int  errors_sent;
    int  idle_requests;
    int  probs_checked;
    int  hold_left;
    bit  no_idle;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // departure intensity out of state s
    function automatic longint unsigned leave_rate(int s);
        longint unsigned busy;
        longint unsigned waiting;
        busy    = (s < cur_cfg.server_count) ? s : cur_cfg.server_count;
        waiting = (s > cur_cfg.server_count) ? s - cur_cfg.server_count : 0;
        return busy * cur_cfg.service_rate + waiting * cur_cfg.abandon_rate;
    endfunction

    // arrival numerator out of state s; the 1/N factor is moved to the other side
    function automatic longint unsigned join_rate(int s);
        if (cur_cfg.source_count == 0)
            return cur_cfg.arrival_rate;
        if (s >= cur_cfg.source_count)
            return 0;
        return longint'(cur_cfg.arrival_rate) * (cur_cfg.source_count - s);
    endfunction

    // weight / total as Q0.32, rounded half up, saturated at all ones
    function automatic logic [31:0] weight_share(bit [BIG_W-1:0] w, bit [BIG_W-1:0] sum);
        bit [BIG_W-1:0]  r;
        longint unsigned q;
        r = w;
        q = 0;
        if (r >= sum) begin
            r = r - sum;
            q = 1;
        end
        for (int b = 0; b < PROB_BITS; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= sum) begin
                r = r - sum;
                q = q | 1;
            end
        end
        r = r << 1;
        if (r >= sum)
            q++;
        if (q > 64'hFFFF_FFFF)
            q = 64'hFFFF_FFFF;
        return q[31:0];
    endfunction

    // product-form solution of the chain, queued as expected probabilities
    task automatic predict_solve();
        bit [BIG_W-1:0] wt[MAX_STATES];
        bit [BIG_W-1:0] sum;
        bit [BIG_W-1:0] dn;
        t_prob_result   r;
        int             n_states;
        n_states = cur_cfg.server_count + cur_cfg.queue_capacity + 1;
        if (n_states > MAX_STATES) begin
            r.state_index  = '0;
            r.probability  = '0;
            r.config_error = 1'b1;
            r.last_result  = 1'b1;
            expected_probs.push_back(r);
            return;
        end
        dn  = (cur_cfg.source_count == 0) ? 1 : cur_cfg.source_count;
        sum = '0;
        for (int k = 0; k < n_states; k++) begin
            wt[k] = 1;
            for (int s = 0; s < k; s++)
                wt[k] = wt[k] * BIG_W'(join_rate(s));
            for (int s = k + 1; s < n_states; s++)
                wt[k] = wt[k] * dn * BIG_W'(leave_rate(s));
            sum = sum + wt[k];
        end
        for (int k = 0; k < n_states; k++) begin
            r.state_index  = k[5:0];
            r.probability  = (sum == 0) ? 32'd0 : weight_share(wt[k], sum);
            r.config_error = 1'b0;
            r.last_result  = (k + 1 == n_states);
            expected_probs.push_back(r);
        end
    endtask

    // result side: check each accepted probability, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_probs.size() == 0) begin
                $display("%0t: result with nothing expected, got idx %0d prob %h err %b last %b",
                         $time, o_state_index, o_probability, o_config_error, o_last_result);
                mismatches++;
            end else begin
                t_prob_result e;
                e = expected_probs.pop_front();
                probs_checked++;
                if (o_state_index !== e.state_index) begin
                    $display("%0t: state_index expected %0d actual %0d",
                             $time, e.state_index, o_state_index);
                    mismatches++;
                end
                if (o_probability !== e.probability) begin
                    $display("%0t: probability (state %0d) expected %h actual %h",
                             $time, e.state_index, e.probability, o_probability);
                    mismatches++;
                end
                if (o_config_error !== e.config_error) begin
                    $display("%0t: config_error expected %b actual %b",
                             $time, e.config_error, o_config_error);
                    mismatches++;
                end
                if (o_last_result !== e.last_result) begin
                    $display("%0t: last_result expected %b actual %b",
                             $time, e.last_result, o_last_result);
                    mismatches++;
                end
            end
        end
        // a long hold-off lets the output back up into the request side
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= no_idle || ($urandom_range(99) >= 18);
        end
    end

    // one register write; only called while nothing is in flight
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SERVER_COUNT:   cur_cfg.server_count   = data[5:0];
            CFG_QUEUE_CAPACITY: cur_cfg.queue_capacity = data[5:0];
            CFG_ARRIVAL_RATE:   cur_cfg.arrival_rate   = data;
            CFG_SERVICE_RATE:   cur_cfg.service_rate   = data;
            CFG_ABANDON_RATE:   cur_cfg.abandon_rate   = data;
            CFG_SOURCE_COUNT:   cur_cfg.source_count   = data[15:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(logic [5:0] srv, logic [5:0] cap, logic [31:0] arr,
                             logic [31:0] svc, logic [31:0] abn, logic [15:0] src);
        write_reg(CFG_SERVER_COUNT, {26'd0, srv});
        write_reg(CFG_QUEUE_CAPACITY, {26'd0, cap});
        write_reg(CFG_ARRIVAL_RATE, arr);
        write_reg(CFG_SERVICE_RATE, svc);
        write_reg(CFG_ABANDON_RATE, abn);
        write_reg(CFG_SOURCE_COUNT, {16'd0, src});
    endtask

    // offer one request; valid stays high after acceptance until the caller
    // offers the next one or calls end_requests in the same step
    task automatic send_request(bit want_solve);
        while (!no_idle && $urandom_range(99) < 18) begin
            i_valid <= 1'b0;
            i_solve_request <= $urandom_range(1);
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_solve_request <= want_solve;
        do @(posedge i_clk); while (!o_ready);
        if (want_solve) begin
            predict_solve();
            if (cur_cfg.server_count + cur_cfg.queue_capacity + 1 > MAX_STATES)
                errors_sent++;
            else
                solves_sent++;
        end else begin
            idle_requests++;
        end
    endtask

    task automatic end_requests();
        i_valid <= 1'b0;
    endtask

    // wait for every probability, then a margin for dropped requests
    task automatic drain();
        end_requests();
        while (expected_probs.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_rate(bit nonzero);
        case ($urandom_range(4))
            0: return 32'hFFFF_FFFF;
            1: return nonzero ? 32'd1 : 32'd0;
            2: return $urandom;
            default: return $urandom_range(32'h0004_0000, 32'h0000_4000);
        endcase
    endfunction

    // defaults after reset: one server, no waiting room, equal rates
    task automatic test_reset_defaults();
        send_request(1'b1);
        drain();
    endtask

    // a low request is taken and gives nothing
    task automatic test_no_request();
        repeat (4) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain();
    endtask

    task automatic test_rate_extremes();
        write_all(6'd1, 6'd2, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 16'd0);
        send_request(1'b1);
        drain();
        write_all(6'd2, 6'd1, 32'd1, 32'hFFFF_FFFF, 32'd0, 16'd0);
        send_request(1'b1);
        drain();
    endtask

    // no arrivals: state zero holds all the mass
    task automatic test_probability_one();
        write_all(6'd2, 6'd1, 32'd0, 32'h0001_0000, 32'h0000_8000, 16'd0);
        send_request(1'b1);
        drain();
    endtask

    // finite sources, one smaller and one far larger than the chain: arrivals stop at the population
    task automatic test_finite_source();
        write_all(6'd1, 6'd2, 32'h0003_0000, 32'h0001_0000, 32'h0000_4000, 16'd1);
        send_request(1'b1);
        drain();
        write_all(6'd1, 6'd1, 32'h0002_0000, 32'h0001_0000, 32'd0, 16'hFFFF);
        send_request(1'b1);
        drain();
    endtask

    // far and just above the limit errors out; the full 64-state chain is solved once
    task automatic test_oversize();
        write_all(6'd63, 6'd62, 32'h0001_0000, 32'h0001_0000, 32'd0, 16'd0);
        send_request(1'b1);
        drain();
        write_reg(CFG_QUEUE_CAPACITY, 32'd1);
        send_request(1'b1);
        drain();
        write_all(6'd63, 6'd0, 32'h0020_0000, 32'h0000_C000, 32'd0, 16'd0);
        send_request(1'b1);
        drain();
    endtask

    // receiver stalls long while error requests keep coming
    task automatic test_backpressure();
        write_all(6'd40, 6'd40, $urandom, 32'h0001_0000, $urandom, $urandom_range(65535));
        hold_left = 300;
        repeat (20) send_request(1'b1);
        drain();
    endtask

    // random configurations, mostly oversize ones with a share of small chains
    task automatic test_random_mix();
        int sent;
        int n_req;
        int srv;
        sent = 0;
        while (sent < 270) begin
            // a quiet stretch with no idling on either side
            no_idle = (sent >= 100 && sent < 150);
            if ($urandom_range(9) < 6) begin
                srv = $urandom_range(63, 1);
                write_all(srv, $urandom_range(62, 64 - srv), pick_rate(0), pick_rate(1),
                          pick_rate(0), $urandom_range(65535));
                n_req = $urandom_range(16, 8);
            end else begin
                srv = $urandom_range(3, 1);
                write_all(srv, $urandom_range(3 - srv, 0), pick_rate(0), pick_rate(1),
                          pick_rate(0), ($urandom_range(2) == 0) ? 0 : $urandom_range(65535) %
                          (($urandom_range(1) == 0) ? 5 : 65536));
                n_req = $urandom_range(2, 1);
            end
            for (int i = 0; i < n_req; i++) begin
                if ($urandom_range(4) == 0)
                    send_request(1'b0);
                send_request(1'b1);
                sent++;
            end
            drain();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_solve_request = 1'b0;
        i_ready         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_SERVER_COUNT;
        i_cfg_data      = '0;
        mismatches      = 0;
        solves_sent     = 0;
        errors_sent     = 0;
        idle_requests   = 0;
        probs_checked   = 0;
        hold_left       = 0;
        no_idle         = 1'b0;
        cur_cfg = '{server_count: 6'd1, queue_capacity: 6'd0, arrival_rate: 32'h0001_0000,
                    service_rate: 32'h0001_0000, abandon_rate: 32'd0, source_count: 16'd0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_no_request();
        test_rate_extremes();
        test_probability_one();
        test_finite_source();
        test_oversize();
        test_backpressure();
        test_random_mix();

        $display("covered %0d solves, %0d oversize errors, %0d dropped requests",
                 solves_sent, errors_sent, idle_requests);
        $display("checked %0d probability results against the product-form predictor",
                 probs_checked);
        if (mismatches == 0 && expected_probs.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // the single 64-state solve dominates; this is many times the slowest run
    initial begin
        #300_000_000;
        $display("timeout with %0d results outstanding", expected_probs.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

### birth_death_queue_steady_state_top.f
src/bdq_pkg.sv
src/bdq_factor.sv
src/bdq_solver.sv
src/birth_death_queue_steady_state_top.sv
test/tb_birth_death_queue_steady_state_top.sv
